>>> rtl/core/b2dd_pkg.sv
`default_nettype none

package b2dd_pkg;

   // string shape
   localparam int DIGIT_COUNT = 10;
   localparam int STAGE_COUNT = DIGIT_COUNT - 1;
   localparam int VALUE_W     = 32;
   localparam int PLACES_W    = 4;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = $clog2(DIGIT_COUNT);
   localparam int WIDE_W      = VALUE_W + 2;

   localparam logic [PLACES_W-1:0] MAX_PLACES = PLACES_W'(DIGIT_COUNT - 1);
   localparam logic [COUNT_W-1:0]  LAST_INDEX = COUNT_W'(DIGIT_COUNT - 1);

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // powers of ten, index is the exponent
   localparam logic [WIDE_W-1:0] POW10 [DIGIT_COUNT] = '{
      34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
      34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
   };

   typedef logic [3:0] digit_type;

   // one transaction inside the digit pipeline
   typedef struct packed {
      logic [VALUE_W-1:0]                rest;
      digit_type [DIGIT_COUNT-1:0]       digits;
      logic [PLACES_W-1:0]               places;
   } conv_type;

   // finished digits, index 0 is the most significant
   typedef struct packed {
      digit_type [DIGIT_COUNT-1:0]       digits;
      logic [PLACES_W-1:0]               places;
   } digits_type;

   // display string, index 0 is the first character out
   typedef logic [DIGIT_COUNT-1:0][CHAR_W-1:0] text_type;

endpackage

`default_nettype wire

>>> rtl/core/b2dd_digit_pipe.sv
`default_nettype none

module b2dd_digit_pipe import b2dd_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_stall,
   input  wire [VALUE_W-1:0]   in_value,
   input  wire [PLACES_W-1:0]  in_places,
   output logic                out_valid,
   input  wire                 out_stall,
   output digits_type          out_data
);

   logic     vld_w [STAGE_COUNT+1];
   conv_type src_w [STAGE_COUNT+1];
   conv_type head;
   logic     advance;

   // whole pipe moves together unless the tail is blocked
   assign advance  = !(vld_w[STAGE_COUNT] && out_stall);
   assign in_stall = !advance;

   // pipeline head with saturated place count
   assign vld_w[0] = in_valid;
   always_comb begin
      head.rest   = in_value;
      head.digits = '0;
      head.places = (in_places > MAX_PLACES) ? MAX_PLACES : in_places;
   end
   assign src_w[0] = head;

   // one decimal digit per stage, most significant first
   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      logic     valid_ff;
      conv_type data_ff;
      conv_type data_in;

      // parallel compares against multiples of this stage's weight
      always_comb begin
         logic [WIDE_W-1:0] ext;
         logic [WIDE_W-1:0] sub;
         digit_type         q;
         ext = {2'b00, src_w[k].rest};
         sub = '0;
         q   = '0;
         for (int m = 1; m < 10; m++) begin
            if (ext >= WIDE_W'(m) * POW10[DIGIT_COUNT-1-k]) begin
               q   = 4'(m);
               sub = WIDE_W'(m) * POW10[DIGIT_COUNT-1-k];
            end
         end
         data_in           = src_w[k];
         data_in.rest      = VALUE_W'(ext - sub);
         data_in.digits[k] = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            data_ff <= data_in;
         end
      end

      assign vld_w[k+1] = valid_ff;
      assign src_w[k+1] = data_ff;
   end

   // the remainder left after the last stage is the units digit
   assign out_valid = vld_w[STAGE_COUNT];
   always_comb begin
      out_data.digits                = src_w[STAGE_COUNT].digits;
      out_data.digits[DIGIT_COUNT-1] = src_w[STAGE_COUNT].rest[3:0];
      out_data.places                = src_w[STAGE_COUNT].places;
   end

endmodule

`default_nettype wire

>>> rtl/core/b2dd_format.sv
`default_nettype none

module b2dd_format import b2dd_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          in_valid,
   output logic         in_stall,
   input  digits_type   in_data,
   output logic         out_valid,
   input  wire          out_stall,
   output text_type     out_text
);

   logic     vld_ff;
   text_type text_ff;
   text_type text_in;
   logic     load;

   assign load     = !vld_ff || !out_stall;
   assign in_stall = !load;

   // point insertion and leading zero blanking
   always_comb begin
      text_type            chars;
      logic [PLACES_W-1:0] point_pos;
      logic [PLACES_W-1:0] blank_lim;
      logic                run;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         chars[i] = CHAR_ZERO | {4'b0000, in_data.digits[i]};
      end
      point_pos = MAX_PLACES - in_data.places;

      // digits ahead of the point move up one place, top digit dropped
      text_in = chars;
      if (in_data.places != '0) begin
         for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
            if (PLACES_W'(i) < point_pos) begin
               text_in[i] = chars[i+1];
            end else if (PLACES_W'(i) == point_pos) begin
               text_in[i] = CHAR_POINT;
            end
         end
      end

      // blanking stops before the units digit or the digit ahead of the point
      if (in_data.places == '0) begin
         blank_lim = MAX_PLACES;
      end else if (in_data.places == MAX_PLACES) begin
         blank_lim = '0;
      end else begin
         blank_lim = point_pos - PLACES_W'(1);
      end

      run = 1'b1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         run = run && (PLACES_W'(i) < blank_lim) && (text_in[i] == CHAR_ZERO);
         if (run) begin
            text_in[i] = CHAR_SPACE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         text_ff <= text_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_text  = text_ff;

endmodule

`default_nettype wire

>>> rtl/core/b2dd_serializer.sv
`default_nettype none

module b2dd_serializer import b2dd_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_stall,
   input  text_type           in_text,
   output logic               out_valid,
   input  wire                out_stall,
   output logic [CHAR_W-1:0]  out_character,
   output logic               out_last
);

   logic               busy_ff;
   text_type           buf_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               done;
   logic               take;

   // a new string loads in the cycle the last character leaves
   assign done     = busy_ff && !out_stall && (count_ff == LAST_INDEX);
   assign take     = !busy_ff || done;
   assign in_stall = !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (take) begin
         busy_ff  <= in_valid;
         count_ff <= '0;
      end else if (!out_stall) begin
         count_ff <= count_ff + COUNT_W'(1);
      end
   end

   // shift out toward index zero
   always_ff @(posedge clock) begin
      if (take) begin
         buf_ff <= in_text;
      end else if (!out_stall) begin
         buf_ff <= buf_ff >> CHAR_W;
      end
   end

   assign out_valid     = busy_ff;
   assign out_character = buf_ff[0];
   assign out_last      = (count_ff == LAST_INDEX);

endmodule

`default_nettype wire

>>> rtl/core/binary_to_decimal_display_string_core.sv
`default_nettype none

// Renders a 32-bit unsigned value as a ten-character decimal display string,
// optionally with a decimal point (req_decimal_places 0 to 9, larger counts
// act as 9) and leading zeros shown as spaces. Each request transaction
// returns ten response transactions, first character first, rsp_last set on
// the tenth. The serializer sends one character per cycle unless rsp_stall
// is set, and the next request is taken while the current string is still
// going out. A character is never sent twice or skipped under rsp_stall.
// From request to first character the data passes nine digit extraction
// stages (one decimal digit each, by parallel compare and subtract), one
// formatting stage and the serializer register.
module binary_to_decimal_display_string_core import b2dd_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire [VALUE_W-1:0]   req_value,
   input  wire [PLACES_W-1:0]  req_decimal_places,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [CHAR_W-1:0]   rsp_character,
   output logic                rsp_last
);

   logic       dig_valid;
   logic       dig_stall;
   digits_type dig_data;
   logic       fmt_valid;
   logic       fmt_stall;
   text_type   fmt_text;

   // binary to decimal digits
   b2dd_digit_pipe u_digit_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_value  (req_value),
      .in_places (req_decimal_places),
      .out_valid (dig_valid),
      .out_stall (dig_stall),
      .out_data  (dig_data)
   );

   // decimal point and blanking
   b2dd_format u_format (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_stall  (dig_stall),
      .in_data   (dig_data),
      .out_valid (fmt_valid),
      .out_stall (fmt_stall),
      .out_text  (fmt_text)
   );

   // one character per transaction
   b2dd_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (fmt_valid),
      .in_stall      (fmt_stall),
      .in_text       (fmt_text),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_character (rsp_character),
      .out_last      (rsp_last)
   );

`ifndef ASSERT_OFF
   // a string runs without gaps until its last character
   a_string_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("response string broke before last character");

   // a new string only loads when the serializer is free or its last character leaves
   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      fmt_valid && !fmt_stall |-> !rsp_valid || (!rsp_stall && rsp_last))
      else $error("string loaded over one still being sent");

   // only digits, point or space leave the block
   a_char_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_POINT) || (rsp_character == CHAR_SPACE)
         || ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_ZERO + 8'd9)))
      else $error("illegal display character");
`endif

endmodule

`default_nettype wire
